### rtl/uscp_pkg.sv
// Shared types and constants for the UART sync command parser.
package uscp_pkg;

  localparam logic [15:0] SyncData  = 16'hAAAA;
  localparam logic [15:0] SyncParam = 16'hCCCC;
  localparam logic [15:0] SyncFile  = 16'hBBBB;
  localparam logic [15:0] SyncAfter = 16'h0101;

  localparam logic CmdByte    = 1'b0;
  localparam logic CmdFileEnd = 1'b1;

  localparam logic [1:0] ModeHandshake = 2'd0;
  localparam logic [1:0] ModeData      = 2'd1;
  localparam logic [1:0] ModeFile      = 2'd2;

  localparam logic [1:0] KindData  = 2'd0;
  localparam logic [1:0] KindParam = 2'd1;
  localparam logic [1:0] KindFile  = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        frame_done;
    logic [1:0]  frame_kind;
    logic        forward_request;
    logic [1:0]  op_mode;
    logic [15:0] standby_threshold;
    logic [7:0]  rx_channel;
    logic        in_frame;
  } res_t;

endpackage

### rtl/uscp_if.sv
// Valid/ready channel interfaces for parser input beats and result beats.
interface uscp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface uscp_out_if;
  logic        valid;
  logic        ready;
  logic        frame_done;
  logic [1:0]  frame_kind;
  logic        forward_request;
  logic [1:0]  op_mode;
  logic [15:0] standby_threshold;
  logic [7:0]  rx_channel;
  logic        in_frame;

  modport source (output valid, output frame_done, output frame_kind,
                  output forward_request, output op_mode, output standby_threshold,
                  output rx_channel, output in_frame, input ready);
  modport sink   (input valid, input frame_done, input frame_kind,
                  input forward_request, input op_mode, input standby_threshold,
                  input rx_channel, input in_frame, output ready);
endinterface

### rtl/uscp_core.sv
// Parser state: sync shift register, frame capture and mode/parameter registers.
module uscp_core #(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  uscp_pkg::item_t item_i,
  output uscp_pkg::res_t  res_o
);

  localparam int unsigned IdxW = $clog2(FRAME_BYTES);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(FRAME_BYTES - 1);
  localparam logic [IdxW-1:0] Idx0 = IdxW'(0);
  localparam logic [IdxW-1:0] Idx1 = IdxW'(1);
  localparam logic [IdxW-1:0] Idx2 = IdxW'(2);

  logic [15:0]     sync_q, sync_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      b0_q, b0_d, b1_q, b1_d, b2_q, b2_d;
  logic [1:0]      mode_q, mode_d;
  logic [15:0]     thr_q, thr_d;
  logic [7:0]      chan_q, chan_d;
  logic            is_sync;
  logic            done;
  logic [1:0]      kind;
  logic            fwd;

  assign is_sync = (sync_q == uscp_pkg::SyncData) || (sync_q == uscp_pkg::SyncParam) ||
                   (sync_q == uscp_pkg::SyncFile);

  always_comb begin
    sync_d = sync_q;
    idx_d  = idx_q;
    b0_d   = b0_q;
    b1_d   = b1_q;
    b2_d   = b2_q;
    mode_d = mode_q;
    thr_d  = thr_q;
    chan_d = chan_q;
    done   = 1'b0;
    kind   = uscp_pkg::KindData;
    fwd    = 1'b0;
    if (accept_i) begin
      if (item_i.cmd == uscp_pkg::CmdFileEnd) begin
        mode_d = uscp_pkg::ModeData;
      end else if (is_sync) begin
        if (idx_q == Idx0) b0_d = item_i.rx_byte;
        if (idx_q == Idx1) b1_d = item_i.rx_byte;
        if (idx_q == Idx2) b2_d = item_i.rx_byte;
        if (idx_q == IdxLast) begin
          idx_d  = Idx0;
          done   = 1'b1;
          sync_d = uscp_pkg::SyncAfter;
          case (sync_q)
            uscp_pkg::SyncData: begin
              kind   = uscp_pkg::KindData;
              fwd    = 1'b1;
              mode_d = uscp_pkg::ModeData;
            end
            uscp_pkg::SyncParam: begin
              kind   = uscp_pkg::KindParam;
              thr_d  = {b0_d, b1_d};
              chan_d = b2_d;
              mode_d = uscp_pkg::ModeHandshake;
            end
            default: begin
              kind   = uscp_pkg::KindFile;
              mode_d = uscp_pkg::ModeFile;
            end
          endcase
        end else begin
          idx_d = idx_q + Idx1;
        end
      end else begin
        sync_d = {sync_q[7:0], item_i.rx_byte};
        idx_d  = Idx0;
      end
    end
  end

  always_comb begin
    res_o.frame_done        = done;
    res_o.frame_kind        = kind;
    res_o.forward_request   = fwd;
    res_o.op_mode           = mode_d;
    res_o.standby_threshold = thr_d;
    res_o.rx_channel        = chan_d;
    res_o.in_frame          = (sync_d == uscp_pkg::SyncData) ||
                              (sync_d == uscp_pkg::SyncParam) ||
                              (sync_d == uscp_pkg::SyncFile);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= '0;
      idx_q  <= '0;
      mode_q <= uscp_pkg::ModeHandshake;
      thr_q  <= 16'd1;
      chan_q <= 8'd1;
    end else begin
      sync_q <= sync_d;
      idx_q  <= idx_d;
      mode_q <= mode_d;
      thr_q  <= thr_d;
      chan_q <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q <= b0_d;
    b1_q <= b1_d;
    b2_q <= b2_d;
  end

endmodule

### rtl/uart_sync_command_parser.sv
// Top level of the UART sync command parser with result register and skid stage.
//
//   channel  modport       beat
//   in_i     uscp_in_if    cmd, rx_byte
//   res_o    uscp_out_if   frame_done .. in_frame, one result per input beat
//
// One input beat per cycle while in_i.ready is high; results leave res_o in order.
// The parser state updates in the accepting cycle, so back-to-back beats see it.
// A result register plus a one-entry skid stage keep in_i.ready high while one
// result waits; ready drops only when both hold results.
// Reset clears the sync register, frame index and both result slots.
module uart_sync_command_parser #(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uscp_in_if.sink    in_i,
  uscp_out_if.source res_o
);

  logic            accept;
  uscp_pkg::item_t item;
  uscp_pkg::res_t  res_new;
  uscp_pkg::res_t  out_q, out_d, skid_q, skid_d;
  logic            out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;

  assign in_i.ready   = !skid_vld_q;
  assign accept       = in_i.valid && !skid_vld_q;
  assign item.cmd     = in_i.cmd;
  assign item.rx_byte = in_i.rx_byte;

  uscp_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (item),
    .res_o   (res_new)
  );

  always_comb begin
    out_d      = out_q;
    skid_d     = skid_q;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (skid_vld_q) begin
      if (res_o.ready) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (accept) begin
      if (!out_vld_q || res_o.ready) begin
        out_d     = res_new;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res_new;
        skid_vld_d = 1'b1;
      end
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_o.valid             = out_vld_q;
  assign res_o.frame_done        = out_q.frame_done;
  assign res_o.frame_kind        = out_q.frame_kind;
  assign res_o.forward_request   = out_q.forward_request;
  assign res_o.op_mode           = out_q.op_mode;
  assign res_o.standby_threshold = out_q.standby_threshold;
  assign res_o.rx_channel        = out_q.rx_channel;
  assign res_o.in_frame          = out_q.in_frame;

endmodule

### tb/tb_top.sv
// Testbench for the UART sync command parser: directed table, then random framed traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN     = 8;
  localparam int DIRECTED_BEATS = 25;
  localparam int RANDOM_BEATS   = 400;

  typedef struct packed {
    logic            typed;
    uscp_pkg::item_t beat;
    uscp_pkg::res_t  want;
  } row_t;

  localparam uscp_pkg::res_t NoRes = '0;

  localparam row_t DirectedRows [DIRECTED_BEATS] = '{
    {1'b1, uscp_pkg::CmdByte, 8'h00,
     {1'b0, uscp_pkg::KindData, 1'b0, uscp_pkg::ModeHandshake, 16'h0001, 8'h01, 1'b0}},
    {1'b1, uscp_pkg::CmdFileEnd, 8'h00,
     {1'b0, uscp_pkg::KindData, 1'b0, uscp_pkg::ModeData, 16'h0001, 8'h01, 1'b0}},
    {1'b1, uscp_pkg::CmdByte, 8'hFF,
     {1'b0, uscp_pkg::KindData, 1'b0, uscp_pkg::ModeData, 16'h0001, 8'h01, 1'b0}},
    {1'b0, uscp_pkg::CmdByte,    8'hCC, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'hCC, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'hFF, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'hFF, NoRes},
    {1'b0, uscp_pkg::CmdFileEnd, 8'hA5, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'h00, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'h80, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'h7F, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'h01, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'hFE, NoRes},
    {1'b1, uscp_pkg::CmdByte, 8'h55,
     {1'b1, uscp_pkg::KindParam, 1'b0, uscp_pkg::ModeHandshake, 16'hFFFF, 8'h00, 1'b0}},
    {1'b0, uscp_pkg::CmdByte,    8'hAA, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'hAA, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'h00, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'hFF, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'hAA, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'hCC, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'hBB, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'h01, NoRes},
    {1'b0, uscp_pkg::CmdByte,    8'h02, NoRes},
    {1'b1, uscp_pkg::CmdByte, 8'hFF,
     {1'b1, uscp_pkg::KindData, 1'b1, uscp_pkg::ModeData, 16'hFFFF, 8'h00, 1'b0}},
    {1'b1, uscp_pkg::CmdFileEnd, 8'hFF,
     {1'b0, uscp_pkg::KindData, 1'b0, uscp_pkg::ModeData, 16'hFFFF, 8'h00, 1'b0}}
  };

  logic clk_i;
  logic rst_ni;

  uscp_in_if  in_ch ();
  uscp_out_if res_ch ();

  uart_sync_command_parser #(
    .FRAME_BYTES(FRAME_LEN)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .res_o (res_ch)
  );

  logic [15:0] sync_q;
  int          frame_pos;
  logic [7:0]  frame_store [3];
  logic [1:0]  mode_q;
  logic [15:0] thresh_q;
  logic [7:0]  chan_q;

  uscp_pkg::res_t pending_results [$];
  int             mismatches = 0;
  int             beats_sent = 0;
  int             burst_left = 0;
  logic [7:0]     stall_cyc  = '0;

  function automatic logic is_sync_word(logic [15:0] w);
    return w == uscp_pkg::SyncData || w == uscp_pkg::SyncParam || w == uscp_pkg::SyncFile;
  endfunction

  function automatic uscp_pkg::res_t parse_beat(uscp_pkg::item_t b);
    uscp_pkg::res_t r;
    r = '0;
    if (b.cmd == uscp_pkg::CmdFileEnd) begin
      mode_q = uscp_pkg::ModeData;
    end else if (is_sync_word(sync_q)) begin
      if (frame_pos < 3) frame_store[frame_pos] = b.rx_byte;
      frame_pos++;
      if (frame_pos >= FRAME_LEN) begin
        frame_pos = 0;
        r.frame_done = 1'b1;
        case (sync_q)
          uscp_pkg::SyncData: begin
            r.frame_kind = uscp_pkg::KindData;
            r.forward_request = 1'b1;
            mode_q = uscp_pkg::ModeData;
          end
          uscp_pkg::SyncParam: begin
            r.frame_kind = uscp_pkg::KindParam;
            thresh_q = {frame_store[0], frame_store[1]};
            chan_q = frame_store[2];
            mode_q = uscp_pkg::ModeHandshake;
          end
          default: begin
            r.frame_kind = uscp_pkg::KindFile;
            mode_q = uscp_pkg::ModeFile;
          end
        endcase
        sync_q = uscp_pkg::SyncAfter;
      end
    end else begin
      sync_q = {sync_q[7:0], b.rx_byte};
      frame_pos = 0;
    end
    r.op_mode = mode_q;
    r.standby_threshold = thresh_q;
    r.rx_channel = chan_q;
    r.in_frame = is_sync_word(sync_q);
    return r;
  endfunction

  task automatic send_row(input row_t r);
    uscp_pkg::res_t predicted;
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 8);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd = r.beat.cmd;
    in_ch.rx_byte = r.beat.rx_byte;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = parse_beat(r.beat);
    pending_results.push_back(r.typed ? r.want : predicted);
    burst_left--;
    beats_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(negedge clk_i) begin
    stall_cyc <= stall_cyc + 8'd1;
    case (stall_cyc[7:6])
      2'd0:    res_ch.ready <= 1'b1;
      2'd1:    res_ch.ready <= 1'($urandom_range(0, 1));
      2'd2:    res_ch.ready <= (stall_cyc[2:0] != 3'd0);
      default: res_ch.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin : check_beat
    uscp_pkg::res_t got;
    uscp_pkg::res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = {res_ch.frame_done, res_ch.frame_kind, res_ch.forward_request, res_ch.op_mode,
             res_ch.standby_threshold, res_ch.rx_channel, res_ch.in_frame};
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.frame_done !== want.frame_done) begin
          $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
          mismatches++;
        end
        if (got.frame_kind !== want.frame_kind) begin
          $error("frame_kind: expected %0d, got %0d", want.frame_kind, got.frame_kind);
          mismatches++;
        end
        if (got.forward_request !== want.forward_request) begin
          $error("forward_request: expected %0d, got %0d",
                 want.forward_request, got.forward_request);
          mismatches++;
        end
        if (got.op_mode !== want.op_mode) begin
          $error("op_mode: expected %0d, got %0d", want.op_mode, got.op_mode);
          mismatches++;
        end
        if (got.standby_threshold !== want.standby_threshold) begin
          $error("standby_threshold: expected %h, got %h",
                 want.standby_threshold, got.standby_threshold);
          mismatches++;
        end
        if (got.rx_channel !== want.rx_channel) begin
          $error("rx_channel: expected %h, got %h", want.rx_channel, got.rx_channel);
          mismatches++;
        end
        if (got.in_frame !== want.in_frame) begin
          $error("in_frame: expected %0d, got %0d", want.in_frame, got.in_frame);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int          pick;
    int          n;
    logic [15:0] word;
    logic [7:0]  fill;
    bit          flat;

    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = uscp_pkg::CmdByte;
    in_ch.rx_byte = 8'h00;
    res_ch.ready = 1'b0;

    sync_q = '0;
    frame_pos = 0;
    frame_store = '{8'h00, 8'h00, 8'h00};
    mode_q = uscp_pkg::ModeHandshake;
    thresh_q = 16'h0001;
    chan_q = 8'h01;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIRECTED_BEATS; i++) send_row(DirectedRows[i]);
    hold_until_drained();

    while (beats_sent < DIRECTED_BEATS + RANDOM_BEATS) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        repeat ($urandom_range(0, 2)) send_row({1'b0, uscp_pkg::CmdByte, 8'($urandom), NoRes});
        case ($urandom_range(0, 2))
          0:       word = uscp_pkg::SyncData;
          1:       word = uscp_pkg::SyncParam;
          default: word = uscp_pkg::SyncFile;
        endcase
        send_row({1'b0, uscp_pkg::CmdByte, word[15:8], NoRes});
        send_row({1'b0, uscp_pkg::CmdByte, word[7:0], NoRes});
        flat = ($urandom_range(0, 4) == 0);
        fill = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        for (n = 0; n < FRAME_LEN; n++) begin
          if ($urandom_range(0, 11) == 0)
            send_row({1'b0, uscp_pkg::CmdFileEnd, 8'($urandom), NoRes});
          send_row({1'b0, uscp_pkg::CmdByte, flat ? fill : 8'($urandom), NoRes});
        end
      end else if (pick < 16) begin
        send_row({1'b0, uscp_pkg::CmdByte, 8'(8'hAA + 8'h11 * $urandom_range(0, 2)), NoRes});
        send_row({1'b0, uscp_pkg::CmdByte, 8'($urandom), NoRes});
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 4))
          send_row({1'b0, 1'($urandom_range(0, 1)), 8'($urandom), NoRes});
      end else if (pick == 18) begin
        send_row({1'b0, uscp_pkg::CmdFileEnd, 8'($urandom), NoRes});
      end else begin
        hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d expected results never arrived", pending_results.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
